// File: rtl/ffta_pkg.sv
package ffta_pkg;

    localparam int POOL_DEPTH = 256;
    localparam int TAG_WIDTH  = 8;
    localparam int ADDR_W     = $clog2(POOL_DEPTH);
    localparam int CNT_W      = ADDR_W + 1;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NO_FIT    = 2'd1;
    localparam logic [1:0] STAT_NOT_ALLOC = 2'd2;
    localparam logic [1:0] STAT_ZERO_SIZE = 2'd3;

    localparam logic [CNT_W-1:0] POOL_RESET = CNT_W'(POOL_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_FREE
    } ffta_state_t;

    function automatic logic [TAG_WIDTH-1:0] tag_advance(input logic [TAG_WIDTH-1:0] t);
        logic [TAG_WIDTH-1:0] n;
        n = t + 1'b1;
        if (n == '0)
        begin
            n = TAG_WIDTH'(1);
        end
        return n;
    endfunction

endpackage

// File: rtl/ffta_ram.sv
module ffta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/first_fit_tagged_allocator_unit.sv
// zero size allocate or free outside the pool: done in the cycle after the start transfer
// allocate: one unit scanned per cycle; no fit answers once every unit of the pool has been read
// (without a read when the pool is empty); a fit writes the current tag to each unit of the block, then answers
// free clears the run of units holding the tag at free_address; a free unit there answers not-allocated
// one request at a time, next start taken in the done cycle; the receiver cannot stall
// reset clears the whole map at once through per-unit valid flops, tag 1, pool_size 256
module first_fit_tagged_allocator_unit
    import ffta_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 req_type,
    input  logic [CNT_W-1:0]     alloc_size,
    input  logic [ADDR_W-1:0]    free_address,
    output logic                 done,
    output logic [1:0]           status,
    output logic [ADDR_W-1:0]    block_address,
    output logic [TAG_WIDTH-1:0] block_tag,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CNT_W-1:0]     cfg_data
);

    ffta_state_t state_reg, state_next;
    logic [CNT_W-1:0]     pool_reg;
    logic [TAG_WIDTH-1:0] tag_reg, tag_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     chk_reg, chk_next;
    logic                 pend_reg, pend_next;
    logic                 first_reg, first_next;
    logic [CNT_W-1:0]     run_reg, run_next;
    logic [CNT_W-1:0]     size_reg, size_next;
    logic [ADDR_W-1:0]    blk_reg, blk_next;
    logic [TAG_WIDTH-1:0] ftag_reg, ftag_next;
    logic                 done_reg, done_next;
    logic [1:0]           status_reg, status_next;
    logic [ADDR_W-1:0]    baddr_reg, baddr_next;
    logic [TAG_WIDTH-1:0] btag_reg, btag_next;

    logic [POOL_DEPTH-1:0] valid_reg;
    logic                  vld_rd_reg;

    logic [CNT_W-1:0]     n_units;
    logic                 rd_go;
    logic                 ram_we;
    logic                 set_en;
    logic                 clr_en;
    logic [TAG_WIDTH-1:0] ram_rdata;
    logic [TAG_WIDTH-1:0] map_data;
    logic [CNT_W-1:0]     run_inc;
    logic [CNT_W-1:0]     start_idx;

    assign n_units   = (pool_reg > POOL_RESET) ? POOL_RESET : pool_reg;
    assign map_data  = vld_rd_reg ? ram_rdata : '0;
    assign run_inc   = run_reg + 1'b1;
    assign start_idx = chk_reg + 1'b1 - size_reg;
    assign rd_go     = (idx_reg < n_units);

    assign busy          = (state_reg != ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign done          = done_reg;
    assign status        = status_reg;
    assign block_address = baddr_reg;
    assign block_tag     = btag_reg;

    ffta_ram #(
        .WIDTH(TAG_WIDTH),
        .DEPTH(POOL_DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg[ADDR_W-1:0]),
        .wdata (tag_reg),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pool_reg  <= POOL_RESET;
            tag_reg   <= TAG_WIDTH'(1);
            done_reg  <= 1'b0;
            valid_reg <= '0;
            pend_reg  <= 1'b0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tag_reg   <= tag_next;
            done_reg  <= done_next;
            pend_reg  <= pend_next;
            first_reg <= first_next;
            if (cfg_valid && cfg_ready)
            begin
                pool_reg <= cfg_data;
            end
            if (set_en)
            begin
                valid_reg[idx_reg[ADDR_W-1:0]] <= 1'b1;
            end
            if (clr_en)
            begin
                valid_reg[chk_reg[ADDR_W-1:0]] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        chk_reg    <= chk_next;
        run_reg    <= run_next;
        size_reg   <= size_next;
        blk_reg    <= blk_next;
        ftag_reg   <= ftag_next;
        status_reg <= status_next;
        baddr_reg  <= baddr_next;
        btag_reg   <= btag_next;
        vld_rd_reg <= valid_reg[idx_reg[ADDR_W-1:0]];
    end

    always_comb
    begin
        state_next  = state_reg;
        tag_next    = tag_reg;
        idx_next    = idx_reg;
        chk_next    = chk_reg;
        pend_next   = pend_reg;
        first_next  = first_reg;
        run_next    = run_reg;
        size_next   = size_reg;
        blk_next    = blk_reg;
        ftag_next   = ftag_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        baddr_next  = baddr_reg;
        btag_next   = btag_reg;
        ram_we      = 1'b0;
        set_en      = 1'b0;
        clr_en      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (req_type == REQ_FREE)
                    begin
                        if ({1'b0, free_address} >= n_units)
                        begin
                            done_next   = 1'b1;
                            status_next = STAT_NOT_ALLOC;
                            baddr_next  = '0;
                            btag_next   = '0;
                        end
                        else
                        begin
                            state_next = ST_FREE;
                            idx_next   = {1'b0, free_address};
                            pend_next  = 1'b0;
                            first_next = 1'b1;
                        end
                    end
                    else if (alloc_size == '0)
                    begin
                        done_next   = 1'b1;
                        status_next = STAT_ZERO_SIZE;
                        baddr_next  = '0;
                        btag_next   = tag_reg;
                        tag_next    = tag_advance(tag_reg);
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                        idx_next   = '0;
                        pend_next  = 1'b0;
                        run_next   = '0;
                        size_next  = alloc_size;
                    end
                end
            end

            ST_SCAN:
            begin
                pend_next = rd_go;
                if (rd_go)
                begin
                    idx_next = idx_reg + 1'b1;
                    chk_next = idx_reg;
                end
                if (pend_reg)
                begin
                    if (map_data == '0)
                    begin
                        run_next = run_inc;
                        if (run_inc == size_reg)
                        begin
                            state_next = ST_WRITE;
                            idx_next   = start_idx;
                            chk_next   = chk_reg;
                            blk_next   = start_idx[ADDR_W-1:0];
                        end
                    end
                    else
                    begin
                        run_next = '0;
                    end
                end
                else if (!rd_go)
                begin
                    state_next  = ST_IDLE;
                    done_next   = 1'b1;
                    status_next = STAT_NO_FIT;
                    baddr_next  = '0;
                    btag_next   = tag_reg;
                    tag_next    = tag_advance(tag_reg);
                end
            end

            ST_WRITE:
            begin
                ram_we = 1'b1;
                set_en = 1'b1;
                if (idx_reg == chk_reg)
                begin
                    state_next  = ST_IDLE;
                    done_next   = 1'b1;
                    status_next = STAT_OK;
                    baddr_next  = blk_reg;
                    btag_next   = tag_reg;
                    tag_next    = tag_advance(tag_reg);
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ST_FREE:
            begin
                pend_next = rd_go;
                if (rd_go)
                begin
                    idx_next = idx_reg + 1'b1;
                    chk_next = idx_reg;
                end
                if (pend_reg)
                begin
                    if (first_reg)
                    begin
                        if (map_data == '0)
                        begin
                            state_next  = ST_IDLE;
                            done_next   = 1'b1;
                            status_next = STAT_NOT_ALLOC;
                            baddr_next  = '0;
                            btag_next   = '0;
                        end
                        else
                        begin
                            ftag_next  = map_data;
                            first_next = 1'b0;
                            clr_en     = 1'b1;
                        end
                    end
                    else if (map_data == ftag_reg)
                    begin
                        clr_en = 1'b1;
                    end
                    else
                    begin
                        state_next  = ST_IDLE;
                        done_next   = 1'b1;
                        status_next = STAT_OK;
                        baddr_next  = '0;
                        btag_next   = ftag_reg;
                    end
                end
                else if (!rd_go)
                begin
                    state_next  = ST_IDLE;
                    done_next   = 1'b1;
                    status_next = STAT_OK;
                    baddr_next  = '0;
                    btag_next   = ftag_reg;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || start))
        else $error("result strobe without a request in flight");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !start) |=> !busy)
        else $error("became busy without a start");

    a_tag_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        tag_reg != '0)
        else $error("current tag took the free marker");

    a_fail_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != STAT_OK) |-> (block_address == '0 && !busy))
        else $error("failed request returned a block address");
`endif

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ffta_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 2 * POOL_DEPTH + 16;
    localparam int NUM_ROWS       = 20;

    typedef struct packed {
        logic [1:0]           status;
        logic [ADDR_W-1:0]    block_address;
        logic [TAG_WIDTH-1:0] block_tag;
    } alloc_result_t;

    typedef struct packed {
        logic                 req;
        logic [CNT_W-1:0]     size;
        logic [ADDR_W-1:0]    addr;
        logic                 fixed_exp;
        logic [1:0]           status;
        logic [ADDR_W-1:0]    block_address;
        logic [TAG_WIDTH-1:0] block_tag;
    } alloc_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 req_type;
    logic [CNT_W-1:0]     alloc_size;
    logic [ADDR_W-1:0]    free_address;
    logic                 done;
    logic [1:0]           status;
    logic [ADDR_W-1:0]    block_address;
    logic [TAG_WIDTH-1:0] block_tag;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CNT_W-1:0]     cfg_data;

    // shadow copy of the allocator state
    logic [TAG_WIDTH-1:0] tag_map [POOL_DEPTH];
    logic [TAG_WIDTH-1:0] tag_next;
    logic [CNT_W-1:0]     pool_size_cfg;

    alloc_result_t expected_results [$];
    alloc_result_t expected_head;
    int            errors;
    int            quiet_cycles;
    int            sender_idle_pct;

    // tags of the typed rows: every allocate call uses up one tag
    alloc_row_t directed_rows [NUM_ROWS] = '{
        '{REQ_ALLOC, 9'd0,   8'd0,   1'b1, STAT_ZERO_SIZE, 8'd0,   8'd1},
        '{REQ_FREE,  9'd0,   8'd0,   1'b1, STAT_NOT_ALLOC, 8'd0,   8'd0},
        '{REQ_ALLOC, 9'd257, 8'd0,   1'b1, STAT_NO_FIT,    8'd0,   8'd2},
        '{REQ_ALLOC, 9'd256, 8'd0,   1'b1, STAT_OK,        8'd0,   8'd3},
        '{REQ_ALLOC, 9'd1,   8'd0,   1'b1, STAT_NO_FIT,    8'd0,   8'd4},
        '{REQ_FREE,  9'd511, 8'd255, 1'b1, STAT_OK,        8'd0,   8'd3},
        '{REQ_ALLOC, 9'd1,   8'd255, 1'b1, STAT_OK,        8'd255, 8'd5},
        '{REQ_FREE,  9'd0,   8'd0,   1'b1, STAT_OK,        8'd0,   8'd3},
        '{REQ_FREE,  9'd0,   8'd255, 1'b1, STAT_OK,        8'd0,   8'd5},
        '{REQ_ALLOC, 9'd511, 8'd255, 1'b1, STAT_NO_FIT,    8'd0,   8'd6},
        '{REQ_ALLOC, 9'd4,   8'd0,   1'b1, STAT_OK,        8'd0,   8'd7},
        '{REQ_ALLOC, 9'd4,   8'd0,   1'b0, STAT_OK,        8'd0,   8'd0},
        '{REQ_ALLOC, 9'd4,   8'd0,   1'b0, STAT_OK,        8'd0,   8'd0},
        '{REQ_FREE,  9'd0,   8'd4,   1'b0, STAT_OK,        8'd0,   8'd0},
        '{REQ_ALLOC, 9'd5,   8'd0,   1'b0, STAT_OK,        8'd0,   8'd0},
        '{REQ_ALLOC, 9'd3,   8'd0,   1'b0, STAT_OK,        8'd0,   8'd0},
        '{REQ_FREE,  9'd0,   8'd2,   1'b0, STAT_OK,        8'd0,   8'd0},
        '{REQ_ALLOC, 9'd2,   8'd0,   1'b0, STAT_OK,        8'd0,   8'd0},
        '{REQ_FREE,  9'd0,   8'd6,   1'b0, STAT_OK,        8'd0,   8'd0},
        '{REQ_FREE,  9'd0,   8'd7,   1'b0, STAT_OK,        8'd0,   8'd0}
    };

    first_fit_tagged_allocator_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .alloc_size    (alloc_size),
        .free_address  (free_address),
        .done          (done),
        .status        (status),
        .block_address (block_address),
        .block_tag     (block_tag),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int units_in_use();
        return (pool_size_cfg > POOL_DEPTH) ? POOL_DEPTH : int'(pool_size_cfg);
    endfunction

    function automatic alloc_result_t apply_request(input logic req,
                                                    input logic [CNT_W-1:0] size,
                                                    input logic [ADDR_W-1:0] addr);
        alloc_result_t        r;
        int                   n;
        int                   run;
        int                   hit;
        int                   k;
        logic [TAG_WIDTH-1:0] t;
        r = '0;
        n = units_in_use();
        if (req == REQ_ALLOC)
        begin
            r.block_tag = tag_next;
            if (size == 0)
            begin
                r.status = STAT_ZERO_SIZE;
            end
            else
            begin
                run = 0;
                hit = -1;
                for (k = 0; k < n && hit < 0; k++)
                begin
                    run = (tag_map[k] == '0) ? run + 1 : 0;
                    if (run == int'(size))
                    begin
                        hit = k;
                    end
                end
                if (hit >= 0)
                begin
                    for (k = hit + 1 - int'(size); k <= hit; k++)
                    begin
                        tag_map[k] = tag_next;
                    end
                    r.block_address = ADDR_W'(hit + 1 - int'(size));
                end
                else
                begin
                    r.status = STAT_NO_FIT;
                end
            end
            tag_next = tag_next + 1'b1;
            if (tag_next == '0)
            begin
                tag_next = TAG_WIDTH'(1);
            end
        end
        else
        begin
            if (int'(addr) >= n || tag_map[addr] == '0)
            begin
                r.status = STAT_NOT_ALLOC;
            end
            else
            begin
                t = tag_map[addr];
                r.block_tag = t;
                k = int'(addr);
                while (k < n && tag_map[k] == t)
                begin
                    tag_map[k] = '0;
                    k++;
                end
            end
        end
        return r;
    endfunction

    // a live unit of the pool if there is one, most often the first unit of its block
    function automatic logic [ADDR_W-1:0] pick_live_unit();
        int n;
        int origin;
        int idx;
        int j;
        n = units_in_use();
        origin = $urandom_range(POOL_DEPTH - 1);
        for (j = 0; j < POOL_DEPTH; j++)
        begin
            idx = (origin + j) % POOL_DEPTH;
            if (idx < n && tag_map[idx] != '0)
            begin
                if ($urandom_range(99) < 70)
                begin
                    while (idx > 0 && tag_map[idx-1] == tag_map[idx])
                    begin
                        idx--;
                    end
                end
                return ADDR_W'(idx);
            end
        end
        return ADDR_W'(origin);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic queue_expected(input alloc_result_t res);
        expected_results.insert(expected_results.size(), res);
    endtask

    task automatic issue(input logic req, input logic [CNT_W-1:0] size,
                         input logic [ADDR_W-1:0] addr, input logic fixed_exp,
                         input alloc_result_t fixed_res);
        alloc_result_t r;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        req_type     <= req;
        alloc_size   <= size;
        free_address <= addr;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        r = apply_request(req, size, addr);
        queue_expected(fixed_exp ? fixed_res : r);
    endtask

    task automatic set_pool_size(input logic [CNT_W-1:0] value);
        start <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0 || busy)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        pool_size_cfg = value;
    endtask

    task automatic run_random(input int count);
        int               i;
        int               n;
        int               pick;
        logic [CNT_W-1:0] size;
        for (i = 0; i < count; i++)
        begin
            n = units_in_use();
            if ($urandom_range(99) < 60)
            begin
                pick = $urandom_range(99);
                if (pick < 75)
                begin
                    size = CNT_W'($urandom_range(1, 8));
                end
                else if (pick < 90)
                begin
                    size = CNT_W'($urandom_range(1, (n > 1) ? n : 1));
                end
                else if (pick < 95)
                begin
                    size = '0;
                end
                else
                begin
                    size = CNT_W'($urandom_range(511));
                end
                issue(REQ_ALLOC, size, ADDR_W'($urandom_range(255)), 1'b0, '0);
            end
            else
            begin
                issue(REQ_FREE, CNT_W'($urandom_range(511)),
                      ($urandom_range(99) < 75) ? pick_live_unit()
                                                : ADDR_W'($urandom_range(255)),
                      1'b0, '0);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result with no request outstanding, status",
                                    status, 0);
                end
                else
                begin
                    expected_head = expected_results.pop_front();
                    if (status != expected_head.status)
                    begin
                        report_mismatch("status", status, expected_head.status);
                    end
                    if (block_address != expected_head.block_address)
                    begin
                        report_mismatch("block_address", block_address,
                                        expected_head.block_address);
                    end
                    if (block_tag != expected_head.block_tag)
                    begin
                        report_mismatch("block_tag", block_tag, expected_head.block_tag);
                    end
                end
            end
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL first_fit_tagged_allocator_unit");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin
        alloc_result_t row_result;
        int            i;
        rst_n           = 1'b0;
        start           = 1'b0;
        req_type        = REQ_ALLOC;
        alloc_size      = '0;
        free_address    = '0;
        cfg_valid       = 1'b0;
        cfg_data        = '0;
        errors          = 0;
        quiet_cycles    = 0;
        sender_idle_pct = 0;
        for (i = 0; i < POOL_DEPTH; i++)
        begin
            tag_map[i] = '0;
        end
        tag_next      = TAG_WIDTH'(1);
        pool_size_cfg = POOL_RESET;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < NUM_ROWS; i++)
        begin
            row_result.status        = directed_rows[i].status;
            row_result.block_address = directed_rows[i].block_address;
            row_result.block_tag     = directed_rows[i].block_tag;
            issue(directed_rows[i].req, directed_rows[i].size, directed_rows[i].addr,
                  directed_rows[i].fixed_exp, row_result);
        end

        // above depth, clamped
        set_pool_size(9'd511);
        sender_idle_pct = 0;
        run_random(80);

        set_pool_size(9'd1);
        sender_idle_pct = 73;
        run_random(40);

        set_pool_size(9'd0);
        sender_idle_pct = 0;
        run_random(20);

        set_pool_size(CNT_W'($urandom_range(2, 64)));
        sender_idle_pct = 73;
        run_random(100);

        set_pool_size(9'd256);
        sender_idle_pct = 11;
        run_random(100);

        // shrunk pool, upper units keep their tags
        set_pool_size(9'd200);
        sender_idle_pct = 0;
        run_random(60);

        start <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
        begin
            $display("PASS first_fit_tagged_allocator_unit");
        end
        else
        begin
            $display("FAIL first_fit_tagged_allocator_unit");
        end
        $finish;
    end

endmodule

// File: first_fit_tagged_allocator_unit.f
rtl/ffta_pkg.sv
rtl/ffta_ram.sv
rtl/first_fit_tagged_allocator_unit.sv
verif/testbench.sv
